// ----- design/gcd_lcm_unit_defines.svh -----
// assertion macros shared by the gcd/lcm unit
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define GLU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define GLU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/glu_pkg.sv -----
`default_nettype none

package glu_pkg;

  // operand width used by the arithmetic, 8 to 32
  localparam int Width = 32;
  // fixed port widths
  localparam int OpW   = 32;
  localparam int LcmW  = 64;
  // step counter for one division or multiplication
  localparam int CntW  = $clog2(Width + 1);

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StEuclid,
    StQuot,
    StMul,
    StDone
  } state_e;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [Width-1:0] dividend;
    logic [Width-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [Width-1:0] quotient;
    logic [Width-1:0] remainder;
  } div_rsp_t;

  // multiplier request and response
  typedef struct packed {
    logic             start;
    logic [Width-1:0] mcand;
    logic [Width-1:0] mplier;
  } mul_cmd_t;

  typedef struct packed {
    logic               done;
    logic [2*Width-1:0] product;
  } mul_rsp_t;

endpackage

`default_nettype wire

// ----- design/glu_div.sv -----
`default_nettype none

`include "gcd_lcm_unit_defines.svh"

module glu_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire glu_pkg::div_cmd_t div_cmd_i,
  output glu_pkg::div_rsp_t      div_rsp_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [glu_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [glu_pkg::Width-1:0] rem_q, rem_d;
  logic [glu_pkg::Width-1:0] quo_q, quo_d;
  logic [glu_pkg::Width-1:0] dsr_q, dsr_d;
  logic [glu_pkg::Width:0]   shifted;
  logic [glu_pkg::Width:0]   trial;

  // one restoring subtract per cycle
  assign shifted = {rem_q, quo_q[glu_pkg::Width-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (div_cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = glu_pkg::CntW'(glu_pkg::Width);
      rem_d  = '0;
      quo_d  = div_cmd_i.dividend;
      dsr_d  = div_cmd_i.divisor;
    end else if (busy_q) begin
      if (!trial[glu_pkg::Width]) begin
        rem_d = trial[glu_pkg::Width-1:0];
      end else begin
        rem_d = shifted[glu_pkg::Width-1:0];
      end
      quo_d = {quo_q[glu_pkg::Width-2:0], ~trial[glu_pkg::Width]};
      cnt_d = cnt_q - glu_pkg::CntW'(1);
      if (cnt_q == glu_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign div_rsp_o.done      = done_q;
  assign div_rsp_o.quotient  = quo_q;
  assign div_rsp_o.remainder = rem_q;

  `GLU_ASSERT_IMPL(a_div_start_idle, div_cmd_i.start, !busy_q, "divider started while busy")
  `GLU_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q, "divider done held over two cycles")
  `GLU_ASSERT_IMPL(a_div_rem_small, done_q, rem_q < dsr_q, "remainder not below divisor")

endmodule

`default_nettype wire

// ----- design/glu_mul.sv -----
`default_nettype none

`include "gcd_lcm_unit_defines.svh"

module glu_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire glu_pkg::mul_cmd_t mul_cmd_i,
  output glu_pkg::mul_rsp_t      mul_rsp_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [glu_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [glu_pkg::Width-1:0] hi_q, hi_d;
  logic [glu_pkg::Width-1:0] lo_q, lo_d;
  logic [glu_pkg::Width-1:0] mcand_q, mcand_d;
  logic [glu_pkg::Width:0]   sum;

  // add the multiplicand when the low bit of the multiplier is set
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    if (mul_cmd_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = glu_pkg::CntW'(glu_pkg::Width);
      hi_d    = '0;
      lo_d    = mul_cmd_i.mplier;
      mcand_d = mul_cmd_i.mcand;
    end else if (busy_q) begin
      hi_d  = sum[glu_pkg::Width:1];
      lo_d  = {sum[0], lo_q[glu_pkg::Width-1:1]};
      cnt_d = cnt_q - glu_pkg::CntW'(1);
      if (cnt_q == glu_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
  end

  assign mul_rsp_o.done    = done_q;
  assign mul_rsp_o.product = {hi_q, lo_q};

  `GLU_ASSERT_IMPL(a_mul_start_idle, mul_cmd_i.start, !busy_q, "multiplier started while busy")
  `GLU_ASSERT_NEXT(a_mul_done_pulse, done_q, !done_q, "multiplier done held over two cycles")
  `GLU_ASSERT_IMPL(a_mul_done_idle, done_q, !busy_q && cnt_q == '0, "multiplier done mid-run")

endmodule

`default_nettype wire

// ----- design/gcd_lcm_unit.sv -----
// channel | signals                              | direction
// input   | in_valid_i, in_stall_o, a/b_operand  | request in
// output  | out_valid_o, out_stall_i, gcd/lcm/z  | result out
//
// One request at a time; in_stall_o is high from acceptance until the result is taken.
// Steps: accept, k Euclid divisions, the quotient division a / gcd and the multiply by b,
// then the result stage; a zero operand goes from acceptance straight to the result stage.
// The shared restoring divider produces one quotient bit a cycle.
// Reset is asynchronous, active low, and clears the sequencer and unit control only.
// out_stall_i holds the result stage; nothing is dropped or repeated.

`default_nettype none

`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [glu_pkg::OpW-1:0]  a_operand_i,
  input  wire logic [glu_pkg::OpW-1:0]  b_operand_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [glu_pkg::OpW-1:0]       gcd_value_o,
  output logic [glu_pkg::LcmW-1:0]      lcm_value_o,
  output logic                          both_zero_o
);

  glu_pkg::state_e             state_q, state_d;
  glu_pkg::div_cmd_t           div_cmd;
  glu_pkg::div_rsp_t           div_rsp;
  glu_pkg::mul_cmd_t           mul_cmd;
  glu_pkg::mul_rsp_t           mul_rsp;
  logic [glu_pkg::Width-1:0]   a_in, b_in;
  logic                        any_zero;
  logic [glu_pkg::Width-1:0]   a_q, a_d;
  logic [glu_pkg::Width-1:0]   b_q, b_d;
  logic [glu_pkg::Width-1:0]   y_q, y_d;
  logic [glu_pkg::Width-1:0]   gcd_q, gcd_d;
  logic [2*glu_pkg::Width-1:0] lcm_q, lcm_d;
  logic                        zero_q, zero_d;

  // operands masked to the working width
  assign a_in     = a_operand_i[glu_pkg::Width-1:0];
  assign b_in     = b_operand_i[glu_pkg::Width-1:0];
  assign any_zero = (a_in == '0) || (b_in == '0);

  // divider, shared by the Euclid and quotient divisions, and multiplier
  glu_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_cmd_i (div_cmd),
    .div_rsp_o (div_rsp)
  );

  glu_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mul_cmd_i (mul_cmd),
    .mul_rsp_o (mul_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      glu_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = any_zero ? glu_pkg::StDone : glu_pkg::StEuclid;
        end
      end
      glu_pkg::StEuclid: begin
        if (div_rsp.done && div_rsp.remainder == '0) begin
          state_d = glu_pkg::StQuot;
        end
      end
      glu_pkg::StQuot: begin
        if (div_rsp.done) begin
          state_d = glu_pkg::StMul;
        end
      end
      glu_pkg::StMul: begin
        if (mul_rsp.done) begin
          state_d = glu_pkg::StDone;
        end
      end
      glu_pkg::StDone: begin
        if (!out_stall_i) begin
          state_d = glu_pkg::StIdle;
        end
      end
      default: state_d = glu_pkg::StIdle;
    endcase
  end

  // unit requests and datapath updates
  always_comb begin
    div_cmd = '0;
    mul_cmd = '0;
    a_d     = a_q;
    b_d     = b_q;
    y_d     = y_q;
    gcd_d   = gcd_q;
    lcm_d   = lcm_q;
    zero_d  = zero_q;
    unique case (state_q)
      glu_pkg::StIdle: begin
        if (in_valid_i) begin
          a_d    = a_in;
          b_d    = b_in;
          zero_d = (a_in == '0) && (b_in == '0);
          if (any_zero) begin
            gcd_d = a_in | b_in;
            lcm_d = '0;
          end else begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = a_in;
            div_cmd.divisor  = b_in;
            y_d              = b_in;
          end
        end
      end
      glu_pkg::StEuclid: begin
        if (div_rsp.done) begin
          div_cmd.start = 1'b1;
          if (div_rsp.remainder == '0) begin
            // last divisor is the gcd; next form a / gcd
            gcd_d            = y_q;
            div_cmd.dividend = a_q;
            div_cmd.divisor  = y_q;
          end else begin
            div_cmd.dividend = y_q;
            div_cmd.divisor  = div_rsp.remainder;
            y_d              = div_rsp.remainder;
          end
        end
      end
      glu_pkg::StQuot: begin
        if (div_rsp.done) begin
          mul_cmd.start  = 1'b1;
          mul_cmd.mcand  = div_rsp.quotient;
          mul_cmd.mplier = b_q;
        end
      end
      glu_pkg::StMul: begin
        if (mul_rsp.done) begin
          lcm_d = mul_rsp.product;
        end
      end
      glu_pkg::StDone: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glu_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    y_q    <= y_d;
    gcd_q  <= gcd_d;
    lcm_q  <= lcm_d;
    zero_q <= zero_d;
  end

  // handshake and result ports
  assign in_stall_o  = (state_q != glu_pkg::StIdle);
  assign out_valid_o = (state_q == glu_pkg::StDone);
  assign gcd_value_o = glu_pkg::OpW'(gcd_q);
  assign lcm_value_o = glu_pkg::LcmW'(lcm_q);
  assign both_zero_o = zero_q;

  `GLU_ASSERT_IMPL(a_busy_while_out, out_valid_o, in_stall_o, "request taken with result pending")
  `GLU_ASSERT_IMPL(a_zero_result, out_valid_o && both_zero_o,
                   gcd_value_o == '0 && lcm_value_o == '0, "both-zero result not cleared")
  `GLU_ASSERT_IMPL(a_gcd_nonzero, out_valid_o && !both_zero_o, gcd_value_o != '0,
                   "zero gcd without both-zero flag")

endmodule

`default_nettype wire

// ----- tb/gcd_lcm_checker.sv -----
module gcd_lcm_checker (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_stall_i,
  input  wire logic [glu_pkg::OpW-1:0]  a_operand_i,
  input  wire logic [glu_pkg::OpW-1:0]  b_operand_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_stall_i,
  input  wire logic [glu_pkg::OpW-1:0]  gcd_value_i,
  input  wire logic [glu_pkg::LcmW-1:0] lcm_value_i,
  input  wire logic                     both_zero_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   owed_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;

  // one expected result, with the operands kept for the log
  typedef struct packed {
    logic [glu_pkg::OpW-1:0]  a;
    logic [glu_pkg::OpW-1:0]  b;
    logic [glu_pkg::OpW-1:0]  gcd;
    logic [glu_pkg::LcmW-1:0] lcm;
    logic                     both_zero;
  } gcd_lcm_t;

  gcd_lcm_t    owed_results[$];
  int unsigned bad_count  = 0;
  int unsigned owed_count = 0;

  assign fail_count_o = bad_count;
  assign owed_count_o = owed_count;

  // gcd by remainder loop, lcm as (a / gcd) * b at double width
  function automatic gcd_lcm_t compute_gcd_lcm(logic [glu_pkg::OpW-1:0] a_raw,
                                               logic [glu_pkg::OpW-1:0] b_raw);
    logic [glu_pkg::LcmW-1:0] wide_mask;
    logic [glu_pkg::OpW-1:0]  a;
    logic [glu_pkg::OpW-1:0]  b;
    logic [glu_pkg::OpW-1:0]  x;
    logic [glu_pkg::OpW-1:0]  y;
    logic [glu_pkg::OpW-1:0]  r;
    gcd_lcm_t                 res;
    wide_mask = (glu_pkg::LcmW'(1) << glu_pkg::Width) - glu_pkg::LcmW'(1);
    a = a_raw & wide_mask[glu_pkg::OpW-1:0];
    b = b_raw & wide_mask[glu_pkg::OpW-1:0];
    res.a = a_raw;
    res.b = b_raw;
    res.lcm = '0;
    res.both_zero = 1'b0;
    if (a == '0 && b == '0) begin
      res.gcd = '0;
      res.both_zero = 1'b1;
    end else if (a == '0) begin
      res.gcd = b;
    end else if (b == '0) begin
      res.gcd = a;
    end else begin
      x = a;
      y = b;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.gcd = x;
      res.lcm = glu_pkg::LcmW'(a / x) * glu_pkg::LcmW'(b);
    end
    return res;
  endfunction

  // watch both channels, compare results in order
  always @(posedge clk_i) begin
    gcd_lcm_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          if (bad_count < ReportLimit)
            $display("%0t: result with no request outstanding: gcd %h lcm %h zero %b",
                     $time, gcd_value_i, lcm_value_i, both_zero_i);
          bad_count++;
        end else begin
          want = owed_results.pop_front();
          if (gcd_value_i !== want.gcd || lcm_value_i !== want.lcm ||
              both_zero_i !== want.both_zero) begin
            if (bad_count < ReportLimit)
              $display("%0t: a=%h b=%h exp gcd %h lcm %h zero %b, got gcd %h lcm %h zero %b",
                       $time, want.a, want.b, want.gcd, want.lcm, want.both_zero,
                       gcd_value_i, lcm_value_i, both_zero_i);
            bad_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        owed_results.push_back(compute_gcd_lcm(a_operand_i, b_operand_i));
      owed_count = owed_results.size();
    end
  end

endmodule

// ----- tb/tb_gcd_lcm_unit.sv -----
module tb_gcd_lcm_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems   = 1000;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 40;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic [glu_pkg::OpW-1:0]  a_operand = '0;
  logic [glu_pkg::OpW-1:0]  b_operand = '0;
  logic                     out_stall = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [glu_pkg::OpW-1:0]  gcd_value;
  logic [glu_pkg::LcmW-1:0] lcm_value;
  logic                     both_zero;

  int unsigned send_idle_pct  = 26;
  int unsigned recv_stall_pct = 48;
  int unsigned idle_cycles    = 0;
  int unsigned fail_count;
  int unsigned owed_count;

  gcd_lcm_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .a_operand_i (a_operand),
    .b_operand_i (b_operand),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .gcd_value_o (gcd_value),
    .lcm_value_o (lcm_value),
    .both_zero_o (both_zero)
  );

  gcd_lcm_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .a_operand_i  (a_operand),
    .b_operand_i  (b_operand),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .gcd_value_i  (gcd_value),
    .lcm_value_i  (lcm_value),
    .both_zero_i  (both_zero),
    .fail_count_o (fail_count),
    .owed_count_o (owed_count)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // random backpressure on the result side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // hang detection: cycles with no request and no result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("gcd_lcm_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one request, starting and ending at a falling edge
  task automatic send_request(input logic [glu_pkg::OpW-1:0] a,
                              input logic [glu_pkg::OpW-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    a_operand <= a;
    b_operand <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    logic [glu_pkg::OpW-1:0] fib [0:47];
    logic [glu_pkg::OpW-1:0] a;
    logic [glu_pkg::OpW-1:0] b;
    logic [glu_pkg::OpW-1:0] g;
    int unsigned             pick;
    int unsigned             n;

    // hold reset low, then release it at a falling edge
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero operands, extremes, worst-case euclid, exact multiples
    send_request('0, '0);
    send_request('0, 32'd12345);
    send_request(32'd98765, '0);
    send_request('0, '1);
    send_request('1, '0);
    send_request('1, '1);
    send_request(32'd1, 32'd1);
    send_request(32'd1, '1);
    send_request('1, 32'd1);
    send_request('1, 32'hFFFF_FFFE);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'h8000_0000, 32'd1);
    send_request(32'd2971215073, 32'd1836311903);
    send_request(32'd1836311903, 32'd2971215073);
    send_request(32'd12, 32'd18);
    send_request(32'd7, 32'd7 * 32'd613566756);
    send_request(32'd65536, 32'd65536 * 32'd65535);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    send_request(32'd4294967291, 32'd4294967279);
    send_request(32'd1000, 32'd1000);

    // fibonacci pairs drive the longest remainder chains
    fib[0] = '0;
    fib[1] = 32'd1;
    for (int i = 2; i < 48; i++) fib[i] = fib[i-1] + fib[i-2];

    // random requests in three idling phases
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) begin
        send_idle_pct  = 48;
        recv_stall_pct = 26;
      end else if (i == 2 * RandomItems / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        a = $urandom;
        b = $urandom;
      end else if (pick < 55) begin
        // shared factor
        g = $urandom_range(1, 65535);
        a = g * $urandom_range(1, 32'hFFFF_FFFF / g);
        b = g * $urandom_range(1, 32'hFFFF_FFFF / g);
      end else if (pick < 70) begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end else if (pick < 78) begin
        if ($urandom_range(0, 1)) begin
          a = '0;
          b = $urandom;
        end else begin
          a = $urandom;
          b = '0;
        end
      end else if (pick < 82) begin
        a = '0;
        b = '0;
      end else if (pick < 90) begin
        n = $urandom_range(1, 46);
        if ($urandom_range(0, 1)) begin
          a = fib[n+1];
          b = fib[n];
        end else begin
          a = fib[n];
          b = fib[n+1];
        end
      end else if (pick < 95) begin
        a = 32'd1 << $urandom_range(0, 31);
        b = 32'd1 << $urandom_range(0, 31);
      end else begin
        a = $urandom;
        b = a;
      end
      send_request(a, b);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (owed_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && owed_count == 0) begin
      $display("gcd_lcm_unit regression: pass");
    end else begin
      $display("gcd_lcm_unit regression: fail");
    end
    $finish;
  end

endmodule
